### src/fppd_pkg.sv
package fppd_pkg;

    localparam int POOL_ENTRIES = 8;
    localparam int IDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int CNT_W = $clog2(POOL_ENTRIES + 1);
    localparam int KEY_W = 28;

    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_APPEND,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic we;
        idx_t waddr;
        key_t wdata;
        logic re;
        idx_t raddr;
    } ram_req_t;

    typedef struct packed {
        logic hit;
        logic evicted;
        key_t ev_key;
        cnt_t count;
    } result_t;

endpackage

### src/fppd_key_ram.sv
module fppd_key_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/fppd_ctrl.sv
module fppd_ctrl import fppd_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  logic     cmd,
    input  key_t     key,
    input  key_t     rdata,
    output ram_req_t ram_req,
    output logic     res_valid,
    input  logic     res_ready,
    output result_t  result
);

    state_t state_reg, state_next;
    logic   cmd_reg, cmd_next;
    key_t   key_reg, key_next;
    cnt_t   count_reg, count_next;
    cnt_t   scan_reg, scan_next;
    cnt_t   end_reg, end_next;
    logic   pend_reg, pend_next;
    idx_t   pidx_reg, pidx_next;
    logic   hit_reg, hit_next;
    logic   ev_reg, ev_next;
    key_t   ev_key_reg, ev_key_next;
    logic   match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        scan_reg   <= scan_next;
        end_reg    <= end_next;
        pidx_reg   <= pidx_next;
        hit_reg    <= hit_next;
        ev_reg     <= ev_next;
        ev_key_reg <= ev_key_next;
    end

    assign match = pend_reg && (rdata == key_reg);

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        count_next  = count_reg;
        scan_next   = scan_reg;
        end_next    = end_reg;
        pend_next   = pend_reg;
        pidx_next   = pidx_reg;
        hit_next    = hit_reg;
        ev_next     = ev_reg;
        ev_key_next = ev_key_reg;
        ram_req     = '0;
        in_stall    = 1'b1;
        res_valid   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd_next   = cmd;
                    key_next   = key;
                    scan_next  = '0;
                    pend_next  = 1'b0;
                    hit_next   = 1'b0;
                    ev_next    = 1'b0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                // The oldest key is kept in case this access has to evict it.
                if (pend_reg && (pidx_reg == '0))
                begin
                    ev_key_next = rdata;
                end
                if (match)
                begin
                    hit_next  = 1'b1;
                    pend_next = 1'b0;
                    if (cmd_reg == CMD_ACCESS)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        scan_next  = CNT_W'(pidx_reg) + CNT_W'(1);
                        end_next   = count_reg;
                        count_next = count_reg - CNT_W'(1);
                        state_next = ST_SHIFT;
                    end
                end
                else if (scan_reg == count_reg)
                begin
                    pend_next = 1'b0;
                    if (cmd_reg == CMD_DELETE)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (count_reg == CNT_W'(POOL_ENTRIES))
                    begin
                        ev_next    = 1'b1;
                        scan_next  = CNT_W'(1);
                        end_next   = CNT_W'(POOL_ENTRIES);
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = count_reg[IDX_W-1:0];
                        ram_req.wdata = key_reg;
                        count_next    = count_reg + CNT_W'(1);
                        state_next    = ST_FINISH;
                    end
                end
                else
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = scan_reg[IDX_W-1:0];
                    pend_next     = 1'b1;
                    pidx_next     = scan_reg[IDX_W-1:0];
                    scan_next     = scan_reg + CNT_W'(1);
                end
            end
            ST_SHIFT:
            begin
                // Each entry read in the previous cycle moves down by one slot.
                if (pend_reg)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = pidx_reg - IDX_W'(1);
                    ram_req.wdata = rdata;
                end
                if (scan_reg < end_reg)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = scan_reg[IDX_W-1:0];
                    pend_next     = 1'b1;
                    pidx_next     = scan_reg[IDX_W-1:0];
                    scan_next     = scan_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ev_reg ? ST_APPEND : ST_FINISH;
                end
            end
            ST_APPEND:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = IDX_W'(POOL_ENTRIES - 1);
                ram_req.wdata = key_reg;
                state_next    = ST_FINISH;
            end
            ST_FINISH:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result.hit     = hit_reg;
    assign result.evicted = ev_reg;
    assign result.ev_key  = ev_reg ? ev_key_reg : '0;
    assign result.count   = count_reg;

endmodule

### src/fifo_page_pool_directory.sv
// Key directory of a matrix page buffer pool with FIFO replacement.
// Input channel: in_valid/in_stall with cmd (0 access, 1 delete) and the key
// fields matrix_id, page_row and page_col. A transfer happens on a rising edge
// with in_valid high and in_stall low. Every command gives exactly one result.
// Output channel: out_valid/out_stall with hit, evicted, the evicted key fields
// and occupancy, the number of keys held after the command.
// Keys live in a RAM with one read and one write port, kept in age order. The
// search reads one entry a cycle and compares it the cycle after. On a delete
// hit the younger entries slide down one per cycle; an evicting access moves
// each younger entry down by one slot over the oldest and appends the new key
// in the last slot. One command is in work at a time; the next transfer can
// happen the cycle after the current result has entered the output register.
// Reset empties the pool at once; no RAM sweep is needed.
// While out_stall holds a result, the block can finish the next command but
// keeps it until the output register frees up.
module fifo_page_pool_directory import fppd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [7:0]  matrix_id,
    input  logic [9:0]  page_row,
    input  logic [9:0]  page_col,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit,
    output logic        evicted,
    output logic [7:0]  evicted_matrix,
    output logic [9:0]  evicted_row,
    output logic [9:0]  evicted_col,
    output logic [3:0]  occupancy
);

    ram_req_t ram_req;
    key_t     rdata;
    key_t     key;
    result_t  result;
    logic     res_valid;
    logic     res_ready;
    logic     out_valid_reg, out_valid_next;
    result_t  out_reg;

    assign key = {matrix_id, page_row, page_col};

    fppd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .key       (key),
        .rdata     (rdata),
        .ram_req   (ram_req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .result    (result)
    );

    fppd_key_ram #(
        .WIDTH (KEY_W),
        .DEPTH (POOL_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (rdata)
    );

    assign res_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign hit            = out_reg.hit;
    assign evicted        = out_reg.evicted;
    assign evicted_matrix = out_reg.ev_key[27:20];
    assign evicted_row    = out_reg.ev_key[19:10];
    assign evicted_col    = out_reg.ev_key[9:0];
    assign occupancy      = 4'(out_reg.count);

endmodule
